// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Each macro expands to a labeled concurrent assertion in simulation
// and to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== rtl/gbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbf_pkg
// Shared constants, types and helpers of the bridge finder.
// ----------------------------------------------------------------------------
package gbf_pkg;

   localparam int MAX_V    = 64;                 // largest graph
   localparam int IDX_W    = $clog2(MAX_V);      // vertex index
   localparam int CNT_W    = IDX_W + 1;          // vertex count, 1..MAX_V
   localparam int ROW_W    = 64;                 // row_bits field width
   localparam int VID_W    = 7;                  // end_low / end_high width
   localparam int TOT_W    = 6;                  // bridge_total width
   localparam int LIST_D   = MAX_V - 1;          // bridge list depth
   localparam int LIST_AW  = $clog2(LIST_D);
   localparam int PDATA_W  = 32;
   localparam int PADDR_W  = 3;
   localparam logic [PADDR_W-1:0] REG_VERTEX_COUNT = 3'd0;
   localparam logic [CNT_W-1:0]   VC_RESET = CNT_W'(MAX_V);

   // One classified row on its way from the front to the back.
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] row_idx;
      logic [MAX_V-1:0] row_data;
      logic             last;
      logic [CNT_W-1:0] n;
   } entry_type;

   // Clamp a register value to 1..MAX_V.
   function automatic logic [CNT_W-1:0] eff_n(input logic [CNT_W-1:0] vc);
      logic [CNT_W-1:0] n;
      n = vc;
      if (vc == '0) n = CNT_W'(1);
      if (vc > CNT_W'(MAX_V)) n = CNT_W'(MAX_V);
      return n;
   endfunction

   // Bits below n set.
   function automatic logic [MAX_V-1:0] low_mask(input logic [CNT_W-1:0] n);
      logic [MAX_V-1:0] m;
      for (int j = 0; j < MAX_V; j++) m[j] = (CNT_W'(j) < n);
      return m;
   endfunction

endpackage

// ===== rtl/gbf_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbf_req_if
// Row channel: one adjacency row per item.
// ----------------------------------------------------------------------------
interface gbf_req_if import gbf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] row_bits;
   logic             row_last;

   modport source (output valid, row_bits, row_last, input ready);
   modport sink   (input valid, row_bits, row_last, output ready);
endinterface

// ===== rtl/gbf_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbf_rsp_if
// Result channel: count item, then one item per bridge.
// ----------------------------------------------------------------------------
interface gbf_rsp_if import gbf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             is_count;
   logic [TOT_W-1:0] bridge_total;
   logic [VID_W-1:0] end_low;
   logic [VID_W-1:0] end_high;
   logic             run_last;

   modport source (output valid, is_count, bridge_total, end_low, end_high, run_last,
                   input ready);
   modport sink   (input valid, is_count, bridge_total, end_low, end_high, run_last,
                   output ready);
endinterface

// ===== rtl/gbf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/gbf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbf_front
// Accepts rows, keeps the row count, masks each row to its upper triangle within the vertex count.
// ----------------------------------------------------------------------------
module gbf_front import gbf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] vert_n,
   gbf_req_if.sink          req,
   input  logic             q_full,
   output logic             q_push,
   output entry_type        q_entry
);
   logic [CNT_W-1:0] rc_ff, rc_in;
   logic [MAX_V-1:0] keep;

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   always_comb begin
      for (int j = 0; j < MAX_V; j++) begin
         keep[j] = (CNT_W'(j) > rc_ff) && (CNT_W'(j) < vert_n);
      end
      q_entry.wr_en    = (rc_ff < vert_n);
      q_entry.row_idx  = rc_ff[IDX_W-1:0];
      q_entry.row_data = req.row_bits[MAX_V-1:0] & keep;
      q_entry.last     = req.row_last;
      q_entry.n        = vert_n;
   end

   always_comb begin
      rc_in = rc_ff;
      if (q_push) begin
         if (req.row_last) begin
            rc_in = '0;
         end else if (rc_ff < CNT_W'(MAX_V)) begin
            rc_in = rc_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff <= '0;
      end else begin
         rc_ff <= rc_in;
      end
   end
endmodule

// ===== rtl/gbf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbf_queue
// Two-entry queue of classified rows between front and back.
// ----------------------------------------------------------------------------
module gbf_queue import gbf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      full,
   output logic      empty
);
   entry_type  slot_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign head  = slot_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop  ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_entry;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   `include "assert_macros.svh"
   `ASSERT_NEVER(a_q_overflow, clock, reset, push && full && !pop, "queue overflow")
   `ASSERT_NEVER(a_q_underflow, clock, reset, pop && empty, "queue underflow")
   `ASSERT_PROP(a_q_count, clock, reset, (push && !pop && !full) |=> !empty, "lost item")
endmodule

// ===== rtl/gbf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbf_back
// Stores rows, tests every edge for a bridge and sends the results.
// ----------------------------------------------------------------------------
module gbf_back import gbf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  entry_type q_head,
   input  logic      q_empty,
   output logic      q_pop,
   gbf_rsp_if.source rsp
);
   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_ROW_RD   = 10'b0000000010,
      S_ROW_WAIT = 10'b0000000100,
      S_SCAN     = 10'b0000001000,
      S_SW_RD    = 10'b0000010000,
      S_SW_UPD   = 10'b0000100000,
      S_TEST_END = 10'b0001000000,
      S_CNT      = 10'b0010000000,
      S_LRD      = 10'b0100000000,
      S_LOUT     = 10'b1000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] n_ff, n_in, i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [IDX_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [MAX_V-1:0] erow_ff, erow_in, reach_ff, reach_in, valid_ff, valid_in;
   logic             changed_ff, changed_in;
   logic [TOT_W-1:0] cnt_ff, cnt_in;

   logic             rv_ff, rv_in, ric_ff, ric_in, rlast_ff, rlast_in;
   logic [TOT_W-1:0] rtot_ff, rtot_in;
   logic [VID_W-1:0] rlow_ff, rlow_in, rhigh_ff, rhigh_in;

   logic [IDX_W-1:0]   adj_rd_addr;
   logic [MAX_V-1:0]   adj_q, nmask, row_r, grow;
   logic               list_we, out_free, hit;
   logic [2*IDX_W-1:0] list_q;

   gbf_ram #(.WIDTH(MAX_V), .DEPTH(MAX_V)) u_adj (
      .clock   (clock),
      .wr_en   (q_pop && q_head.wr_en),
      .wr_addr (q_head.row_idx),
      .wr_data (q_head.row_data),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_q)
   );

   gbf_ram #(.WIDTH(2*IDX_W), .DEPTH(LIST_D)) u_list (
      .clock   (clock),
      .wr_en   (list_we),
      .wr_addr (cnt_ff[LIST_AW-1:0]),
      .wr_data ({b_ff, a_ff}),
      .rd_addr (k_ff[LIST_AW-1:0]),
      .rd_data (list_q)
   );

   assign nmask       = low_mask(n_ff);
   assign out_free    = !rv_ff || rsp.ready;
   assign adj_rd_addr = (state_ff == S_ROW_RD) ? i_ff[IDX_W-1:0] : k_ff[IDX_W-1:0];
   assign q_pop       = (state_ff == S_IDLE) && !q_empty;
   assign list_we     = (state_ff == S_TEST_END) && !reach_ff[b_ff]
                        && (cnt_ff != TOT_W'(LIST_D));

   always_comb begin
      // row k as read, with the edge under test cut out
      row_r = adj_q & nmask & {MAX_V{valid_ff[k_ff[IDX_W-1:0]]}};
      if (k_ff[IDX_W-1:0] == a_ff) row_r[b_ff] = 1'b0;
      hit  = reach_ff[k_ff[IDX_W-1:0]] || ((row_r & reach_ff) != '0);
      grow = reach_ff | row_r;
      grow[k_ff[IDX_W-1:0]] = 1'b1;
   end

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      erow_in    = erow_ff;
      reach_in   = reach_ff;
      valid_in   = valid_ff;
      changed_in = changed_ff;
      cnt_in     = cnt_ff;
      rv_in      = rv_ff && !rsp.ready;
      ric_in     = ric_ff;
      rtot_in    = rtot_ff;
      rlow_in    = rlow_ff;
      rhigh_in   = rhigh_ff;
      rlast_in   = rlast_ff;

      case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               if (q_head.wr_en) valid_in[q_head.row_idx] = 1'b1;
               if (q_head.last) begin
                  n_in     = q_head.n;
                  i_in     = '0;
                  cnt_in   = '0;
                  state_in = S_ROW_RD;
               end
            end
         end
         S_ROW_RD: begin
            state_in = (i_ff == n_ff) ? S_CNT : S_ROW_WAIT;
         end
         S_ROW_WAIT: begin
            erow_in  = adj_q & nmask & {MAX_V{valid_ff[i_ff[IDX_W-1:0]]}};
            j_in     = i_ff + CNT_W'(1);
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (j_ff >= n_ff) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = S_ROW_RD;
            end else if (erow_ff[j_ff[IDX_W-1:0]]) begin
               a_in       = i_ff[IDX_W-1:0];
               b_in       = j_ff[IDX_W-1:0];
               reach_in   = '0;
               reach_in[i_ff[IDX_W-1:0]] = 1'b1;
               k_in       = '0;
               changed_in = 1'b0;
               state_in   = S_SW_RD;
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
         end
         S_SW_RD: begin
            state_in = S_SW_UPD;
         end
         S_SW_UPD: begin
            if (hit) reach_in = grow;
            if (k_ff == n_ff - CNT_W'(1)) begin
               // end of a sweep: go again only if the set grew
               k_in       = '0;
               changed_in = 1'b0;
               state_in   = (changed_ff || (hit && grow != reach_ff)) ? S_SW_RD
                                                                       : S_TEST_END;
            end else begin
               changed_in = changed_ff || (hit && grow != reach_ff);
               k_in       = k_ff + CNT_W'(1);
               state_in   = S_SW_RD;
            end
         end
         S_TEST_END: begin
            if (list_we) cnt_in = cnt_ff + TOT_W'(1);
            j_in     = j_ff + CNT_W'(1);
            state_in = S_SCAN;
         end
         S_CNT: begin
            if (out_free) begin
               rv_in    = 1'b1;
               ric_in   = 1'b1;
               rtot_in  = cnt_ff;
               rlow_in  = '0;
               rhigh_in = '0;
               rlast_in = (cnt_ff == '0);
               valid_in = '0;
               k_in     = '0;
               state_in = (cnt_ff == '0) ? S_IDLE : S_LRD;
            end
         end
         S_LRD: begin
            state_in = S_LOUT;
         end
         S_LOUT: begin
            if (out_free) begin
               rv_in    = 1'b1;
               ric_in   = 1'b0;
               rtot_in  = '0;
               rlow_in  = VID_W'(list_q[IDX_W-1:0]) + VID_W'(1);
               rhigh_in = VID_W'(list_q[2*IDX_W-1:IDX_W]) + VID_W'(1);
               rlast_in = (k_ff + CNT_W'(1) == CNT_W'(cnt_ff));
               k_in     = k_ff + CNT_W'(1);
               state_in = rlast_in ? S_IDLE : S_LRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      erow_ff    <= erow_in;
      reach_ff   <= reach_in;
      changed_ff <= changed_in;
      ric_ff     <= ric_in;
      rtot_ff    <= rtot_in;
      rlow_ff    <= rlow_in;
      rhigh_ff   <= rhigh_in;
      rlast_ff   <= rlast_in;
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end

   assign rsp.valid        = rv_ff;
   assign rsp.is_count     = ric_ff;
   assign rsp.bridge_total = rtot_ff;
   assign rsp.end_low      = rlow_ff;
   assign rsp.end_high     = rhigh_ff;
   assign rsp.run_last     = rlast_ff;

   `include "assert_macros.svh"
   `ASSERT_PROP(a_sweep_rng, clock, reset, (state_ff == S_SW_UPD) |-> (k_ff < n_ff), "k past n")
   `ASSERT_PROP(a_edge_ord, clock, reset, (state_ff == S_SW_RD) |-> (a_ff < b_ff), "edge order")
   `ASSERT_PROP(a_pair_ord, clock, reset, (rv_ff && !ric_ff) |-> (rlow_ff < rhigh_ff), "ends")
endmodule

// ===== rtl/graph_bridge_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_bridge_finder
// Finds all bridges of an undirected graph loaded one adjacency row per item.
// ----------------------------------------------------------------------------
// - vertex_count sits at byte address 0 of the APB-style port; write it only
//   while idle. Reads return it, pready is always high, reset value is 64.
// - req takes one row per item, bit j = edge to vertex j+1. Only bits above
//   the diagonal and below the vertex count are kept; extra rows are dropped.
// - Rows pass a two-entry queue and are written one per cycle while the
//   engine is idle. row_last starts the search; input stalls once the queue
//   is full.
// - Search: each row is read, then its columns are scanned; each edge is
//   tested by sweeps of the reachable set over all rows, each row read and
//   then merged, sweeps repeating until one adds nothing.
// - rsp: a count item, then one item per bridge (1-based, low first,
//   row-major), run_last on the final one; bridge items come from a list.
//   rsp is registered, so a stalled receiver just holds the item.
// - Reset clears the row counter, the row valid bits and the output.
// ----------------------------------------------------------------------------
module graph_bridge_finder import gbf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   gbf_req_if.sink            req,
   gbf_rsp_if.source          rsp,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);
   // vertex_count register
   logic [CNT_W-1:0] vc_ff, vc_in;
   logic             csr_wr, csr_hit;

   // front to queue to back
   entry_type push_entry, head;
   logic      q_push, q_pop, q_full, q_empty;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   // registers are word addressed
   assign csr_hit = (paddr[PADDR_W-1:2] == REG_VERTEX_COUNT[PADDR_W-1:2]);
   assign prdata  = csr_hit ? {{(PDATA_W-CNT_W){1'b0}}, vc_ff} : '0;

   always_comb begin
      vc_in = vc_ff;
      if (csr_wr && csr_hit) begin
         vc_in = pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= VC_RESET;
      end else begin
         vc_ff <= vc_in;
      end
   end

   // Intake: counts rows and masks each to the upper triangle within the vertex count.
   gbf_front u_front (
      .clock   (clock),
      .reset   (reset),
      .vert_n  (eff_n(vc_ff)),
      .req     (req),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (push_entry)
   );

   gbf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .full       (q_full),
      .empty      (q_empty)
   );

   // Engine: adjacency store, bridge search, result sequencing.
   gbf_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_head  (head),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );
endmodule

// ===== bench/gbf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbf_checker
// Watches the row, result and register ports of the bridge finder, predicts
// the bridges of each loaded graph and compares every result item in order.
// ----------------------------------------------------------------------------
module gbf_checker import gbf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   gbf_req_if                 req,
   gbf_rsp_if                 rsp,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   input  logic               pready,
   output int                 errors,
   output int                 pending
);

   typedef struct packed {
      logic             is_count;
      logic [TOT_W-1:0] total;
      logic [VID_W-1:0] lo;
      logic [VID_W-1:0] hi;
      logic             last;
   } bridge_item_type;

   typedef logic [63:0] graph_type [64];

   bridge_item_type bridge_q[$];
   logic [6:0]      vc_reg;
   logic [63:0]     rows [64];
   int              row_ptr;

   assign pending = bridge_q.size();

   // components of sym over n vertices, with edge a-b optionally removed
   function automatic int count_groups(graph_type sym, int n, bit cut, int a, int b);
      logic [63:0] seen, front, nxt, nb;
      int groups;
      seen = '0;
      groups = 0;
      for (int v = 0; v < n; v++) begin
         if (!seen[v]) begin
            groups++;
            front = 64'd1 << v;
            seen |= front;
            while (front != 0) begin
               nxt = '0;
               for (int x = 0; x < n; x++) begin
                  if (front[x]) begin
                     nb = sym[x];
                     if (cut && x == a) nb[b] = 1'b0;
                     if (cut && x == b) nb[a] = 1'b0;
                     nxt |= nb;
                  end
               end
               nxt &= ~seen;
               seen |= nxt;
               front = nxt;
            end
         end
      end
      return groups;
   endfunction

   task automatic find_bridges();
      graph_type       sym;
      logic [63:0]     keep;
      int              n, base, found;
      bridge_item_type it;
      bridge_item_type br [$];
      n = (vc_reg == 0) ? 1 : (vc_reg > 64) ? 64 : int'(vc_reg);
      keep = (n == 64) ? '1 : ((64'd1 << n) - 1);
      for (int i = 0; i < 64; i++) sym[i] = '0;
      for (int i = 0; i < n; i++)
         for (int j = i + 1; j < n; j++)
            if (rows[i][j] & keep[j]) begin
               sym[i][j] = 1'b1;
               sym[j][i] = 1'b1;
            end
      base = count_groups(sym, n, 1'b0, 0, 0);
      found = 0;
      for (int i = 0; i < n; i++)
         for (int j = i + 1; j < n; j++)
            if (sym[i][j] && found < 63 && count_groups(sym, n, 1'b1, i, j) > base) begin
               it = '{1'b0, '0, VID_W'(i + 1), VID_W'(j + 1), 1'b0};
               br = {br, it};
               found++;
            end
      it = '{1'b1, TOT_W'(found), '0, '0, found == 0};
      bridge_q = {bridge_q, it};
      foreach (br[k]) begin
         it = br[k];
         it.last = (k == found - 1);
         bridge_q = {bridge_q, it};
      end
   endtask

   always @(posedge clock) begin
      bridge_item_type want, got;
      int n;
      if (reset) begin
         vc_reg  <= 7'd64;
         row_ptr = 0;
         for (int i = 0; i < 64; i++) rows[i] = '0;
         errors  = 0;
      end else begin
         if (psel && penable && pwrite && pready
             && paddr[PADDR_W-1:2] == REG_VERTEX_COUNT[PADDR_W-1:2])
            vc_reg <= pwdata[6:0];
         if (req.valid && req.ready) begin
            n = (vc_reg == 0) ? 1 : (vc_reg > 64) ? 64 : int'(vc_reg);
            if (row_ptr < 64) begin
               // keep only the upper triangle within the vertex count
               if (row_ptr < n) rows[row_ptr] = req.row_bits & ~((64'd2 << row_ptr) - 1);
               row_ptr++;
            end
            if (req.row_last) begin
               find_bridges();
               row_ptr = 0;
               for (int i = 0; i < 64; i++) rows[i] = '0;
            end
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.is_count, rsp.bridge_total, rsp.end_low, rsp.end_high,
                    rsp.run_last};
            if (bridge_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result item: expected none, actual %h",
                        $time, got);
            end else begin
               want = bridge_q.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: mismatch: expected cnt=%b tot=%0d lo=%0d hi=%0d last=%b,",
                           $time, want.is_count, want.total, want.lo, want.hi, want.last);
                  $display("   actual cnt=%b tot=%0d lo=%0d hi=%0d last=%b",
                           got.is_count, got.total, got.lo, got.hi, got.last);
               end
            end
         end
      end
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bridge finder bench: directed graphs, then random graphs of mostly small
// size, under several idle/stall mixes. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
   import gbf_pkg::*;

   logic               clock = 1'b0;
   logic               reset;
   logic               psel, penable, pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;
   int                 errors, pending;

   // idle mix: percent of cycles the sender idles / the receiver stalls
   int src_idle_pct = 0;
   int snk_stall_pct = 0;
   int hold_asks = 0;      // bumped by stimulus to ask for a long stall
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int rows_sent;

   localparam int WATCHDOG = 300000;   // cycles with no handshake at all

   gbf_req_if req ();
   gbf_rsp_if rsp ();

   graph_bridge_finder dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   gbf_checker chk (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
   );

   always #5 clock = ~clock;

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asks != hold_seen) begin
         hold_seen <= hold_asks;
         hold_left <= 400;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   // watchdog: give up if nothing moves for too long
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // one row item, with random sender idling before it
   task automatic send_row(input logic [63:0] bits, input logic last);
      while ($urandom_range(99) < src_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid    <= 1'b1;
      req.row_bits <= bits;
      req.row_last <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // register write, only once the block has drained
   task automatic write_vc(input int value);
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);   // search may still be winding down
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= REG_VERTEX_COUNT;
      pwdata  <= PDATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   initial begin
      int vc, n, nrows, density;
      logic [63:0] bits;
      reset        <= 1'b1;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= '0;
      pwdata       <= '0;
      req.valid    <= 1'b0;
      req.row_bits <= '0;
      req.row_last <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // reset count of 64, short matrix: path 2-1-64-3, self-loop and
      // lower-triangle bits that must be dropped
      send_row((64'd1 << 63) | 64'd2, 1'b0);
      send_row(64'd1 | 64'd2, 1'b0);
      send_row(64'd1 << 63, 1'b1);
      // register 0 acts as one vertex: everything masked, no bridges
      write_vc(0);
      send_row('1, 1'b1);
      // complete graph of 4: no bridges
      write_vc(4);
      repeat (3) send_row('1, 1'b0);
      send_row('1, 1'b1);
      // path of 5 with extra rows past the count
      write_vc(5);
      for (int i = 0; i < 5; i++) send_row(64'd1 << (i + 1), 1'b0);
      send_row('1, 1'b0);
      send_row('1, 1'b1);
      // oversized count clamps to 64: one edge 1-6
      write_vc(127);
      send_row(64'd1 << 5, 1'b1);
      // triangle plus pendant vertex
      write_vc(8);
      send_row(64'h6, 1'b0);
      send_row(64'h4 | 64'h8, 1'b1);

      // --- random graphs ---
      rows_sent = 0;
      for (int g = 0; rows_sent < 82 || g < 10; g++) begin
         case (g % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 84; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 84; end
            default: begin src_idle_pct = 18; snk_stall_pct = 18; end
         endcase
         // graphs 7 and 8 follow graph 6 without draining, to load the input
         if (g != 7 && g != 8) begin
            if (g % 5 == 0) begin
               case ($urandom_range(3))
                  0: vc = 64;
                  1: vc = 65 + $urandom_range(62);
                  2: vc = 1;
                  default: vc = 0;
               endcase
            end else begin
               vc = $urandom_range(2, 10);
            end
            write_vc(vc);
         end
         n = (vc == 0) ? 1 : (vc > 64) ? 64 : vc;
         // usually a full matrix, sometimes short, sometimes with extra rows
         case ($urandom_range(5))
            0: nrows = $urandom_range(1, n);
            1: nrows = n + $urandom_range(1, 3);
            default: nrows = n;
         endcase
         if (n > 16) nrows = $urandom_range(1, 12);   // keep big graphs sparse
         density = $urandom_range(3);
         if (g == 6) hold_asks++;       // long receiver hold while rows queue
         for (int r = 0; r < nrows; r++) begin
            if (n > 16) begin
               bits = (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63));
            end else begin
               bits = rand_word();
               for (int k = 0; k < density; k++) bits &= rand_word();
            end
            send_row(bits, r == nrows - 1);
            rows_sent++;
         end
         if (g == 9) begin
            // sender pause until everything has come back
            req.valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
      end

      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
